>>> rtl/core/look_at_basis_defines.svh
// ----------------------------------------------------------------------------
// look_at_basis_defines
// Assertion macros of the look-at basis block, used by its checker lab_checker.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_BASIS_DEFINES_SVH
`define LOOK_AT_BASIS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/lab_pkg.sv
// ----------------------------------------------------------------------------
// lab_pkg
// Shared types and fixed constants of the look-at basis pipeline.
// ----------------------------------------------------------------------------
package lab_pkg;

    // Per-transaction tag that travels down the pipeline with the data.
    typedef struct packed {
        logic valid;
        logic degen;
    } t_tag;

    // The largest normalized magnitude sits in [2^30, 2^31).
    localparam int unsigned MagW      = 31;
    // Sum of three squared magnitudes.
    localparam int unsigned SumW      = 64;
    // One root bit per stage.
    localparam int unsigned RootSteps = 32;
    localparam int unsigned RootW     = 32;

endpackage

>>> rtl/core/lab_norm.sv
// ----------------------------------------------------------------------------
// lab_norm
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// ----------------------------------------------------------------------------
module lab_norm #(
    parameter int unsigned VW  = 33,
    parameter int unsigned F   = 15,
    parameter int unsigned SBW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lab_pkg::t_tag         i_tag,
    input  logic [2:0][VW-1:0]    i_vec,
    input  logic [SBW-1:0]        i_sb,
    output lab_pkg::t_tag         o_tag,
    output logic [2:0][F:0]       o_vec,
    output logic [SBW-1:0]        o_sb
);

    localparam int unsigned MW = lab_pkg::MagW;
    localparam int unsigned SW = lab_pkg::SumW;
    localparam int unsigned RS = lab_pkg::RootSteps;
    localparam int unsigned LW = lab_pkg::RootW;
    localparam int unsigned PW = $clog2(VW);
    localparam int unsigned QW = F + 1;
    localparam int unsigned NW = MW + F + 1;

    typedef struct packed {
        lab_pkg::t_tag         tag;
        logic [2:0]            neg;
        logic [2:0][MW-1:0]    mag;
        logic [SBW-1:0]        sb;
    } t_carry;

    typedef struct packed {
        t_carry                c;
        logic [SW-1:0]         n;
        logic [SW-1:0]         res;
    } t_root;

    typedef struct packed {
        lab_pkg::t_tag         tag;
        logic [2:0]            neg;
        logic [LW-1:0]         l;
        logic [2:0][NW-1:0]    r;
        logic [2:0][QW-1:0]    q;
        logic [SBW-1:0]        sb;
    } t_div;

    // Stage A: magnitudes and their OR.
    lab_pkg::t_tag       r_a_tag;
    logic [2:0]          r_a_neg;
    logic [2:0][VW-1:0]  r_a_mag;
    logic [VW-1:0]       r_a_or;
    logic [SBW-1:0]      r_a_sb;
    logic [2:0][VW-1:0]  n_a_mag;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_a_mag[i] = i_vec[i][VW-1] ? (~i_vec[i] + VW'(1)) : i_vec[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_a_tag <= i_tag;
            for (int i = 0; i < 3; i++) begin
                r_a_neg[i] <= i_vec[i][VW-1];
            end
            r_a_mag <= n_a_mag;
            r_a_or  <= n_a_mag[0] | n_a_mag[1] | n_a_mag[2];
            r_a_sb  <= i_sb;
        end
    end

    // Stage B: position of the leading one of the largest magnitude.
    lab_pkg::t_tag       r_b_tag;
    logic [2:0]          r_b_neg;
    logic [2:0][VW-1:0]  r_b_mag;
    logic [PW-1:0]       r_b_pos;
    logic [SBW-1:0]      r_b_sb;
    logic [PW-1:0]       n_b_pos;

    always_comb begin
        n_b_pos = '0;
        for (int i = 0; i < VW; i++) begin
            if (r_a_or[i]) begin
                n_b_pos = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_b_tag.valid <= r_a_tag.valid;
            r_b_tag.degen <= r_a_tag.degen | (r_a_or == '0);
            r_b_neg       <= r_a_neg;
            r_b_mag       <= r_a_mag;
            r_b_pos       <= n_b_pos;
            r_b_sb        <= r_a_sb;
        end
    end

    // Stage C: move the leading one to bit MW-1 (truncating right shifts).
    t_carry              r_c;
    logic [2:0][MW-1:0]  n_c_mag;
    logic [PW:0]         w_shamt;
    logic [VW+MW-1:0]    w_wide [3];

    always_comb begin
        w_shamt = {1'b0, r_b_pos} + (PW+1)'(1);
        for (int i = 0; i < 3; i++) begin
            w_wide[i]  = {r_b_mag[i], MW'(0)} >> w_shamt;
            n_c_mag[i] = w_wide[i][MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_c.tag <= r_b_tag;
            r_c.neg <= r_b_neg;
            r_c.mag <= n_c_mag;
            r_c.sb  <= r_b_sb;
        end
    end

    // Stage D: squares.
    t_carry               r_d;
    logic [2:0][2*MW-1:0] r_d_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= r_c;
            for (int i = 0; i < 3; i++) begin
                r_d_sq[i] <= r_c.mag[i] * r_c.mag[i];
            end
        end
    end

    // Stage E: sum of squares, root iteration seed.
    t_root r_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.c.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_e.c   <= r_d;
            r_e.n   <= SW'(r_d_sq[0]) + SW'(r_d_sq[1]) + SW'(r_d_sq[2]);
            r_e.res <= '0;
        end
    end

    // Square root, one result bit per stage.
    t_root r_rt [RS];

    for (genvar j = 0; j < RS; j++) begin : g_root
        localparam logic [SW-1:0] Bit = SW'(1) << (SW - 2 - 2 * j);
        t_root         w_in;
        t_root         n_rt;
        logic [SW-1:0] w_trial;

        if (j == 0) begin : g_first
            assign w_in = r_e;
        end else begin : g_next
            assign w_in = r_rt[j-1];
        end

        always_comb begin
            n_rt    = w_in;
            w_trial = w_in.res + Bit;
            if (w_in.n >= w_trial) begin
                n_rt.n   = w_in.n - w_trial;
                n_rt.res = (w_in.res >> 1) + Bit;
            end else begin
                n_rt.res = w_in.res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rt[j].c.tag.valid <= 1'b0;
            end else if (i_en) begin
                r_rt[j] <= n_rt;
            end
        end
    end

    // Divide prep: numerator with half the length added for rounding.
    t_div          r_p;
    logic [LW-1:0] w_len;

    assign w_len = r_rt[RS-1].res[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p.tag.valid <= 1'b0;
        end else if (i_en) begin
            r_p.tag <= r_rt[RS-1].c.tag;
            r_p.neg <= r_rt[RS-1].c.neg;
            r_p.l   <= w_len;
            r_p.sb  <= r_rt[RS-1].c.sb;
            r_p.q   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_p.r[i] <= (NW'(r_rt[RS-1].c.mag[i]) << F) + NW'(w_len >> 1);
            end
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes.
    t_div r_dv [QW];

    for (genvar d = 0; d < QW; d++) begin : g_div
        localparam int unsigned K = F - d;
        t_div          w_in;
        t_div          n_dv;
        logic [NW-1:0] w_lk;

        if (d == 0) begin : g_first
            assign w_in = r_p;
        end else begin : g_next
            assign w_in = r_dv[d-1];
        end

        always_comb begin
            n_dv = w_in;
            w_lk = NW'(w_in.l) << K;
            for (int i = 0; i < 3; i++) begin
                if (w_in.r[i] >= w_lk) begin
                    n_dv.r[i]    = w_in.r[i] - w_lk;
                    n_dv.q[i][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[d].tag.valid <= 1'b0;
            end else if (i_en) begin
                r_dv[d] <= n_dv;
            end
        end
    end

    // Sign and saturation of +1.0.
    lab_pkg::t_tag    r_o_tag;
    logic [2:0][F:0]  r_o_vec;
    logic [SBW-1:0]   r_o_sb;
    logic [2:0][F:0]  n_o_vec;
    logic [QW-1:0]    w_q [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q[i] = r_dv[QW-1].q[i];
            if (r_dv[QW-1].neg[i]) begin
                n_o_vec[i] = ~w_q[i] + QW'(1);
            end else if (w_q[i][F]) begin
                n_o_vec[i] = {1'b0, {F{1'b1}}};
            end else begin
                n_o_vec[i] = w_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_o_tag <= r_dv[QW-1].tag;
            r_o_vec <= n_o_vec;
            r_o_sb  <= r_dv[QW-1].sb;
        end
    end

    assign o_tag = r_o_tag;
    assign o_vec = r_o_vec;
    assign o_sb  = r_o_sb;

endmodule

>>> rtl/core/lab_cross.sv
// ----------------------------------------------------------------------------
// lab_cross
// Two-stage cross product of two signed unit vectors, exact result.
// ----------------------------------------------------------------------------
module lab_cross #(
    parameter int unsigned F   = 15,
    parameter int unsigned SBW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lab_pkg::t_tag         i_tag,
    input  logic [2:0][F:0]       i_a,
    input  logic [2:0][F:0]       i_b,
    input  logic [SBW-1:0]        i_sb,
    output lab_pkg::t_tag         o_tag,
    output logic [2:0][2*F+2:0]   o_vec,
    output logic [SBW-1:0]        o_sb
);

    localparam int unsigned PW = 2 * F + 2;
    localparam int unsigned CW = 2 * F + 3;

    lab_pkg::t_tag        r_m_tag;
    logic [5:0][PW-1:0]   r_m_prod;
    logic [SBW-1:0]       r_m_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_m_tag     <= i_tag;
            r_m_sb      <= i_sb;
            r_m_prod[0] <= PW'($signed(i_a[1]) * $signed(i_b[2]));
            r_m_prod[1] <= PW'($signed(i_a[2]) * $signed(i_b[1]));
            r_m_prod[2] <= PW'($signed(i_a[2]) * $signed(i_b[0]));
            r_m_prod[3] <= PW'($signed(i_a[0]) * $signed(i_b[2]));
            r_m_prod[4] <= PW'($signed(i_a[0]) * $signed(i_b[1]));
            r_m_prod[5] <= PW'($signed(i_a[1]) * $signed(i_b[0]));
        end
    end

    lab_pkg::t_tag        r_s_tag;
    logic [2:0][CW-1:0]   r_s_vec;
    logic [SBW-1:0]       r_s_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_s_tag <= r_m_tag;
            r_s_sb  <= r_m_sb;
            for (int i = 0; i < 3; i++) begin
                r_s_vec[i] <= {r_m_prod[2*i][PW-1], r_m_prod[2*i]}
                            - {r_m_prod[2*i+1][PW-1], r_m_prod[2*i+1]};
            end
        end
    end

    assign o_tag = r_s_tag;
    assign o_vec = r_s_vec;
    assign o_sb  = r_s_sb;

endmodule

>>> rtl/core/look_at_basis.sv
// ----------------------------------------------------------------------------
// look_at_basis
// Fixed-point look-at camera basis: forward, right and up axes from an eye
// point, a target point and a world-up vector.
// ----------------------------------------------------------------------------
// Usage. One request transaction on the slave stream carries eye, target and
// world-up (signed Q16.16 at the default width). One result transaction on the
// master stream carries the right, camera-up and forward axes in signed Q1.15,
// with +1.0 saturated to the largest positive code. The tuser bit flags a
// degenerate request (eye equals target, zero up, or up parallel to the view
// direction); all axes are then zero.
// Throughput is one transaction per cycle while the result stream is not
// stalled. A request passes through an input register, four normalizers of
// 40 + AXIS_FRAC_BITS stages each (32 of them square-root steps,
// AXIS_FRAC_BITS + 1 divide steps), two two-stage cross products and the
// output register.
// The whole pipeline advances together. When the receiver holds tready low
// with a result waiting, every stage holds and tready on the slave side drops
// until the result is taken; nothing is lost or repeated. Pipeline bubbles
// travel as invalid slots. After reset all valid bits are clear and the block
// is ready at once.
// ----------------------------------------------------------------------------
module look_at_basis #(
    parameter int unsigned COORD_WIDTH    = 32,
    parameter int unsigned AXIS_FRAC_BITS = 15
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Request stream.
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // From bit 0: eye_x, eye_y, eye_z, target_x, target_y, target_z,
    // world_up_x, world_up_y, world_up_z.
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    // Result stream.
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // From bit 0: right_x, right_y, right_z, cam_up_x, cam_up_y, cam_up_z,
    // fwd_x, fwd_y, fwd_z; zero padding above.
    output logic [((9*(AXIS_FRAC_BITS+1)+7)/8)*8-1:0] o_m_axis_tdata,
    // Bit 0: degenerate.
    output logic [0:0] o_m_axis_tuser
);

    localparam int unsigned CW  = COORD_WIDTH;
    localparam int unsigned F   = AXIS_FRAC_BITS;
    localparam int unsigned AW  = F + 1;
    localparam int unsigned XW  = 2 * F + 3;
    localparam int unsigned ODW = ((9 * AW + 7) / 8) * 8;

    // The whole pipeline moves when the output register is free or taken.
    logic w_en;
    logic r_out_valid;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // Input register: view direction as an exact one-bit-wider difference.
    lab_pkg::t_tag       r_in_tag;
    logic [2:0][CW:0]    r_in_dir;
    logic [2:0][CW-1:0]  r_in_up;
    logic [CW-1:0]       w_eye [3];
    logic [CW-1:0]       w_tgt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_eye[i] = i_s_axis_tdata[i*CW +: CW];
            w_tgt[i] = i_s_axis_tdata[(3+i)*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag.valid <= 1'b0;
        end else if (w_en) begin
            r_in_tag.valid <= i_s_axis_tvalid;
            r_in_tag.degen <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_in_dir[i] <= {w_tgt[i][CW-1], w_tgt[i]} - {w_eye[i][CW-1], w_eye[i]};
                r_in_up[i]  <= i_s_axis_tdata[(6+i)*CW +: CW];
            end
        end
    end

    // Forward axis; world-up rides along.
    lab_pkg::t_tag       w_fn_tag;
    logic [2:0][F:0]     w_fn_vec;
    logic [3*CW-1:0]     w_fn_sb;

    lab_norm #(.VW(CW + 1), .F(F), .SBW(3 * CW)) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (r_in_tag),
        .i_vec   (r_in_dir),
        .i_sb    (r_in_up),
        .o_tag   (w_fn_tag),
        .o_vec   (w_fn_vec),
        .o_sb    (w_fn_sb)
    );

    // Normalized world-up; forward rides along.
    lab_pkg::t_tag       w_un_tag;
    logic [2:0][F:0]     w_un_vec;
    logic [3*AW-1:0]     w_un_sb;

    lab_norm #(.VW(CW), .F(F), .SBW(3 * AW)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_fn_tag),
        .i_vec   (w_fn_sb),
        .i_sb    (w_fn_vec),
        .o_tag   (w_un_tag),
        .o_vec   (w_un_vec),
        .o_sb    (w_un_sb)
    );

    // Right direction = up x forward.
    lab_pkg::t_tag       w_cr_tag;
    logic [2:0][XW-1:0]  w_cr_vec;
    logic [3*AW-1:0]     w_cr_sb;

    lab_cross #(.F(F), .SBW(3 * AW)) u_cross_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_un_tag),
        .i_a     (w_un_vec),
        .i_b     (w_un_sb),
        .i_sb    (w_un_sb),
        .o_tag   (w_cr_tag),
        .o_vec   (w_cr_vec),
        .o_sb    (w_cr_sb)
    );

    lab_pkg::t_tag       w_rn_tag;
    logic [2:0][F:0]     w_rn_vec;
    logic [3*AW-1:0]     w_rn_sb;

    lab_norm #(.VW(XW), .F(F), .SBW(3 * AW)) u_norm_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_cr_tag),
        .i_vec   (w_cr_vec),
        .i_sb    (w_cr_sb),
        .o_tag   (w_rn_tag),
        .o_vec   (w_rn_vec),
        .o_sb    (w_rn_sb)
    );

    // Camera up direction = forward x right; both axes ride along.
    lab_pkg::t_tag       w_cu_tag;
    logic [2:0][XW-1:0]  w_cu_vec;
    logic [6*AW-1:0]     w_cu_sb;

    lab_cross #(.F(F), .SBW(6 * AW)) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_rn_tag),
        .i_a     (w_rn_sb),
        .i_b     (w_rn_vec),
        .i_sb    ({w_rn_vec, w_rn_sb}),
        .o_tag   (w_cu_tag),
        .o_vec   (w_cu_vec),
        .o_sb    (w_cu_sb)
    );

    lab_pkg::t_tag       w_vn_tag;
    logic [2:0][F:0]     w_vn_vec;
    logic [6*AW-1:0]     w_vn_sb;

    lab_norm #(.VW(XW), .F(F), .SBW(6 * AW)) u_norm_cam_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_cu_tag),
        .i_vec   (w_cu_vec),
        .i_sb    (w_cu_sb),
        .o_tag   (w_vn_tag),
        .o_vec   (w_vn_vec),
        .o_sb    (w_vn_sb)
    );

    // Output register. A degenerate transaction reports all axes as zero.
    logic [ODW-1:0] r_out_data;
    logic           r_out_degen;
    logic [ODW-1:0] n_out_data;

    always_comb begin
        n_out_data = '0;
        if (!w_vn_tag.degen) begin
            n_out_data[0 +: 3*AW]    = w_vn_sb[3*AW +: 3*AW];
            n_out_data[3*AW +: 3*AW] = w_vn_vec;
            n_out_data[6*AW +: 3*AW] = w_vn_sb[0 +: 3*AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_vn_tag.valid;
            r_out_data  <= n_out_data;
            r_out_degen <= w_vn_tag.degen;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_degen;

endmodule

>>> rtl/core/lab_checker.sv
// ----------------------------------------------------------------------------
// lab_checker
// Port-level checks of the look-at basis block, bound to its top level.
// ----------------------------------------------------------------------------
`include "look_at_basis_defines.svh"

module lab_checker #(
    parameter int unsigned COORD_WIDTH    = 32,
    parameter int unsigned AXIS_FRAC_BITS = 15
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_s_axis_tvalid,
    input logic o_s_axis_tready,
    input logic [((9*COORD_WIDTH+7)/8)*8-1:0]        i_s_axis_tdata,
    input logic o_m_axis_tvalid,
    input logic i_m_axis_tready,
    input logic [((9*(AXIS_FRAC_BITS+1)+7)/8)*8-1:0] o_m_axis_tdata,
    input logic [0:0] o_m_axis_tuser
);

    localparam int unsigned AW = AXIS_FRAC_BITS + 1;

    // A stalled result transaction stays put.
    `LAB_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result changed under stall")

    // Requests are taken whenever no result waits.
    `LAB_ASSERT_NOW(a_ready, !o_m_axis_tvalid, o_s_axis_tready, "not ready with empty output")

    // Degenerate results carry zero axes.
    `LAB_ASSERT_NOW(a_degen_zero, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata == '0, "degenerate result has nonzero axes")

    // A normalized forward axis is never all zero.
    `LAB_ASSERT_NOW(a_fwd_nonzero, o_m_axis_tvalid && !o_m_axis_tuser[0], o_m_axis_tdata[6*AW +: 3*AW] != '0, "zero forward axis")

endmodule

bind look_at_basis lab_checker #(
    .COORD_WIDTH    (COORD_WIDTH),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
) u_lab_checker (.*);
